FILE: design/lar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lar_pkg;

   localparam int COORD_BITS_DEF = 6;
   localparam int GLYPH_BITS     = 7;

   localparam logic [GLYPH_BITS-1:0] GLYPH_BAR  = 7'd124;  // '|'
   localparam logic [GLYPH_BITS-1:0] GLYPH_LOW  = 7'd95;   // '_'
   localparam logic [GLYPH_BITS-1:0] GLYPH_FWD  = 7'd47;   // '/'
   localparam logic [GLYPH_BITS-1:0] GLYPH_BACK = 7'd92;   // backslash

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FLUSH
   } lar_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } lar_cmd_type;

   typedef struct packed {
      logic final_cell;
      logic trail_drop;
   } lar_sts_type;

endpackage

`default_nettype wire

FILE: design/ascii_line_rasterizer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// ASCII line rasterizer: Bresenham stepping with glyph selection.
// Command side: present both endpoints on req_* and raise start; the line is
// taken at the clock edge where start is high and busy is low. busy stays high
// until the line is finished.
// Result side: one cell per beat on rsp_col/rsp_row/rsp_glyph with rsp_last on
// the final cell, each shown for exactly one cycle with rsp_strobe. The
// receiver cannot hold results off; it must take every beat.
// Timing: busy stays high while the line is stepped and, unless a trailing bar
// is dropped, while the held final cell is flushed. The stepping loop produces
// one cell per cycle; a one-cell hold lets the drop of a leading or trailing
// bar be decided before the cell goes out. The first beat passes through the
// hold and the output register after the accept; later ones follow one per
// cycle (a dropped leading bar delays the first beat). Up to 64 cells per
// line at the default size; a new line is taken only once busy is low again.
// Reset: synchronous, active high; the block returns to idle, no beat is
// shown and any line in progress is discarded.

module ascii_line_rasterizer_top import lar_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [COORD_BITS-1:0] req_x_start,
   input  wire logic [COORD_BITS-1:0] req_y_start,
   input  wire logic [COORD_BITS-1:0] req_x_end,
   input  wire logic [COORD_BITS-1:0] req_y_end,
   output logic                       rsp_strobe,
   output logic [COORD_BITS-1:0]      rsp_col,
   output logic [COORD_BITS:0]        rsp_row,
   output logic [GLYPH_BITS-1:0]      rsp_glyph,
   output logic                       rsp_last
);

   lar_cmd_type cmd;
   lar_sts_type sts;

   lar_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   lar_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .rsp_strobe  (rsp_strobe),
      .rsp_col     (rsp_col),
      .rsp_row     (rsp_row),
      .rsp_glyph   (rsp_glyph),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

FILE: design/lar_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lar_ctrl import lar_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire lar_sts_type sts,
   output lar_cmd_type      cmd,
   output logic             busy
);

   lar_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_STEP;
         end
         ST_STEP: begin
            // a dropped trailing bar means the held cell already went out as last
            if (sts.final_cell) state_in = sts.trail_drop ? ST_IDLE : ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/lar_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lar_datapath import lar_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lar_cmd_type           cmd,
   output lar_sts_type                sts,
   input  wire logic [COORD_BITS-1:0] req_x_start,
   input  wire logic [COORD_BITS-1:0] req_y_start,
   input  wire logic [COORD_BITS-1:0] req_x_end,
   input  wire logic [COORD_BITS-1:0] req_y_end,
   output logic                       rsp_strobe,
   output logic [COORD_BITS-1:0]      rsp_col,
   output logic [COORD_BITS:0]        rsp_row,
   output logic [GLYPH_BITS-1:0]      rsp_glyph,
   output logic                       rsp_last
);

   localparam int N = COORD_BITS;
   localparam int E = COORD_BITS + 3;

   // ---- setup from the request ports
   logic signed [N:0] ddx, ddy;
   logic [N:0]        ddx_neg, ddy_neg;
   logic [N-1:0]      adx, ady, dmaj, dmnr;
   logic              dx_zero, dy_zero, dx_pos, dy_pos, steep;
   logic [GLYPH_BITS-1:0] glo, ghi;

   always_comb begin
      ddx     = signed'({1'b0, req_x_end}) - signed'({1'b0, req_x_start});
      ddy     = signed'({1'b0, req_y_end}) - signed'({1'b0, req_y_start});
      ddx_neg = -ddx;
      ddy_neg = -ddy;
      adx     = ddx[N] ? ddx_neg[N-1:0] : ddx[N-1:0];
      ady     = ddy[N] ? ddy_neg[N-1:0] : ddy[N-1:0];
      dx_zero = (ddx == '0);
      dy_zero = (ddy == '0);
      dx_pos  = !ddx[N] && !dx_zero;
      dy_pos  = !ddy[N] && !dy_zero;
      steep   = ady > adx;
      dmaj    = steep ? ady : adx;
      dmnr    = steep ? adx : ady;
      priority if (dx_zero) begin
         glo = GLYPH_BAR;
         ghi = GLYPH_BACK;
      end else if (!dy_zero && (dy_pos == dx_pos)) begin
         glo = steep ? GLYPH_BAR : GLYPH_LOW;
         ghi = GLYPH_BACK;
      end else begin
         glo = (ady < adx) ? GLYPH_LOW : GLYPH_BAR;
         ghi = GLYPH_FWD;
      end
   end

   // ---- stepping registers
   logic [N-1:0]          maj_ff, mnr_ff, steps_ff, xe_ff, ye_ff;
   logic [N:0]            dmaj2_ff, dmnr2_ff;
   logic signed [E-1:0]   err_ff;
   logic                  steep_ff, delta_ff, maj_neg_ff, mnr_neg_ff;
   logic [GLYPH_BITS-1:0] glo_ff, ghi_ff;

   // look-ahead hold
   logic [N-1:0]          hcol_ff;
   logic [N:0]            hrow_ff;
   logic [GLYPH_BITS-1:0] hgly_ff;
   logic                  held_valid_ff, held_valid_in;
   logic                  at_second_ff, at_second_in;
   logic                  first_lt_ff;

   // output register
   logic                  strobe_ff, strobe_in;
   logic [N-1:0]          ocol_ff;
   logic [N:0]            orow_ff;
   logic [GLYPH_BITS-1:0] ogly_ff;
   logic                  olast_ff;

   // ---- current cell
   logic                  pos, final_cell, cur_lt, lt_sel, lead_drop, trail_drop;
   logic [N-1:0]          cell_col, row_base;
   logic [N:0]            cell_row;
   logic [GLYPH_BITS-1:0] cell_gly;
   logic signed [E-1:0]   err_in;

   always_comb begin
      pos        = !err_ff[E-1];
      final_cell = (steps_ff == '0);
      cell_gly   = pos ? ghi_ff : glo_ff;
      priority if (final_cell) begin
         cell_col = xe_ff;
         row_base = ye_ff;
      end else if (steep_ff) begin
         cell_col = mnr_ff;
         row_base = maj_ff;
      end else begin
         cell_col = maj_ff;
         row_base = mnr_ff;
      end
      cell_row   = {1'b0, row_base} + {{N{1'b0}}, pos & delta_ff};
      cur_lt     = hrow_ff < cell_row;
      lt_sel     = at_second_ff ? cur_lt : first_lt_ff;
      lead_drop  = held_valid_ff && at_second_ff && cur_lt && (hgly_ff == GLYPH_BAR);
      trail_drop = held_valid_ff && !lt_sel && (cell_row < hrow_ff)
                   && (cell_gly == GLYPH_BAR);
      err_in     = err_ff + signed'({2'b00, dmnr2_ff})
                   - (pos ? signed'({2'b00, dmaj2_ff}) : signed'({E{1'b0}}));
      sts.final_cell = final_cell;
      sts.trail_drop = final_cell && trail_drop;
   end

   always_comb begin
      held_valid_in = held_valid_ff;
      at_second_in  = at_second_ff;
      strobe_in     = 1'b0;
      if (cmd.load) begin
         held_valid_in = 1'b0;
         at_second_in  = 1'b0;
      end else if (cmd.step) begin
         held_valid_in = 1'b1;
         at_second_in  = !held_valid_ff;
         strobe_in     = held_valid_ff && !lead_drop;
      end else if (cmd.flush) begin
         strobe_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         at_second_ff  <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         at_second_ff  <= at_second_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         steep_ff   <= steep;
         maj_ff     <= steep ? req_y_start : req_x_start;
         mnr_ff     <= steep ? req_x_start : req_y_start;
         maj_neg_ff <= steep ? !dy_pos : !dx_pos;
         mnr_neg_ff <= steep ? !dx_pos : !dy_pos;
         dmaj2_ff   <= {dmaj, 1'b0};
         dmnr2_ff   <= {dmnr, 1'b0};
         err_ff     <= signed'({2'b00, dmnr, 1'b0}) - signed'({3'b000, dmaj});
         steps_ff   <= dmaj;
         glo_ff     <= glo;
         ghi_ff     <= ghi;
         delta_ff   <= !dx_zero && dy_pos && !steep;
         xe_ff      <= req_x_end;
         ye_ff      <= req_y_end;
      end else if (cmd.step) begin
         if (held_valid_ff) begin
            ocol_ff  <= hcol_ff;
            orow_ff  <= hrow_ff;
            ogly_ff  <= hgly_ff;
            olast_ff <= final_cell && trail_drop;
         end
         if (at_second_ff) first_lt_ff <= cur_lt;
         hcol_ff <= cell_col;
         hrow_ff <= cell_row;
         hgly_ff <= cell_gly;
         if (!final_cell) begin
            maj_ff   <= maj_neg_ff ? maj_ff - 1'b1 : maj_ff + 1'b1;
            if (pos) mnr_ff <= mnr_neg_ff ? mnr_ff - 1'b1 : mnr_ff + 1'b1;
            err_ff   <= err_in;
            steps_ff <= steps_ff - 1'b1;
         end
      end else if (cmd.flush) begin
         ocol_ff  <= hcol_ff;
         orow_ff  <= hrow_ff;
         ogly_ff  <= hgly_ff;
         olast_ff <= 1'b1;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_col    = ocol_ff;
   assign rsp_row    = orow_ff;
   assign rsp_glyph  = ogly_ff;
   assign rsp_last   = olast_ff;

endmodule

`default_nettype wire

FILE: design/lar_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lar_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe,
   input wire logic rsp_last
);

   // an accepted line always occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // an idle block with no command stays idle
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !busy)
      else $error("busy raised without a command");

   // beats are produced only while a line is in progress
   a_beat_in_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("beat without a line in progress");

   // the next line cannot deliver a beat right after the last one
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("beat directly after last");

endmodule

bind ascii_line_rasterizer_top lar_checker u_lar_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_last   (rsp_last)
);

`default_nettype wire
